// ===== rtl/gtc_pkg.sv =====
// Shared types, widths, register indexes and reset values of the gesture template classifier.
package gtc_pkg;

  // Field widths of the transfer payloads.
  localparam int FIELD_W      = 10;
  localparam int MASK_W       = 4;
  localparam int NUM_GEST     = 4;
  localparam int NUM_AXES     = 3;

  // Running sums wrap at this width.
  localparam int SUM_W        = 18;

  // Window length needs one bit more than the register to hold 256.
  localparam int SCOUNT_W     = 8;
  localparam int COUNT_W      = SCOUNT_W + 1;

  // Configuration register widths.
  localparam int TOL_W        = 10;
  localparam int REPEAT_W     = 4;
  localparam int TMPL_W       = NUM_AXES * FIELD_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = TMPL_W;

  // Default converter resolution.
  localparam int ADC_BITS_DEF = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOLERANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_UP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_DOWN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_THIRD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_FOURTH = 3'd6;

  // Gesture numbers.
  localparam logic [1:0] GEST_UP     = 2'd0;
  localparam logic [1:0] GEST_DOWN   = 2'd1;
  localparam logic [1:0] GEST_FWD    = 2'd2;
  localparam logic [1:0] GEST_REV    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [SCOUNT_W-1:0] SAMPLE_COUNT_RST    = 8'd100;
  localparam logic [TOL_W-1:0]    MATCH_TOLERANCE_RST = 10'd10;
  localparam logic [REPEAT_W-1:0] REPEAT_COUNT_RST    = 4'd10;
  localparam logic [TMPL_W-1:0]   TEMPLATE_UP_RST     = 30'd362076445;
  localparam logic [TMPL_W-1:0]   TEMPLATE_DOWN_RST   = 30'd299197780;
  localparam logic [TMPL_W-1:0]   TEMPLATE_THIRD_RST  = 30'd390355272;
  localparam logic [TMPL_W-1:0]   TEMPLATE_FOURTH_RST = 30'd351688008;

  // Input transfer payload.
  typedef struct packed {
    logic [FIELD_W-1:0] accel_x;
    logic [FIELD_W-1:0] accel_y;
    logic [FIELD_W-1:0] accel_z;
    logic               limit_clear;
  } gtc_in_t;

  // Result transfer payload.
  typedef struct packed {
    logic [FIELD_W-1:0] avg_x;
    logic [FIELD_W-1:0] avg_y;
    logic [FIELD_W-1:0] avg_z;
    logic [MASK_W-1:0]  match_mask;
    logic [MASK_W-1:0]  move_mask;
    logic               down_blocked;
  } gtc_out_t;

  // Settings that the template matcher works from.
  typedef struct packed {
    logic [TOL_W-1:0]                 tolerance;
    logic [REPEAT_W-1:0]              repeat_count;
    logic [NUM_GEST-1:0][TMPL_W-1:0]  templates;
  } gtc_match_cfg_t;

  // Outcome of one window's template pass.
  typedef struct packed {
    logic [MASK_W-1:0] match_mask;
    logic [MASK_W-1:0] move_mask;
    logic              down_blocked;
  } gtc_match_res_t;

endpackage

// ===== rtl/gtc_accum.sv =====
// Bit-serial accumulator that adds one sample to each of the three axis sums.
module gtc_accum
  import gtc_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              clear,
  input  logic [NUM_AXES-1:0][SUM_W-1:0]    samples,
  output logic [NUM_AXES-1:0][SUM_W-1:0]    sums,
  output logic                              done
);

  localparam int CNT_W = $clog2(SUM_W);

  logic [NUM_AXES-1:0][SUM_W-1:0] sum_r, sum_nxt;
  logic [NUM_AXES-1:0][SUM_W-1:0] samp_r, samp_nxt;
  logic [NUM_AXES-1:0]            carry_r, carry_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [NUM_AXES-1:0][1:0]       bit_sum;

  // One full-adder step per axis and cycle; the sums rotate back into place after SUM_W steps.
  always_comb begin
    sum_nxt   = sum_r;
    samp_nxt  = samp_r;
    carry_nxt = carry_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      bit_sum[a] = {1'b0, sum_r[a][0]} + {1'b0, samp_r[a][0]} + {1'b0, carry_r[a]};
    end
    if (busy_r) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        sum_nxt[a]   = {bit_sum[a][0], sum_r[a][SUM_W-1:1]};
        samp_nxt[a]  = {1'b0, samp_r[a][SUM_W-1:1]};
        carry_nxt[a] = bit_sum[a][1];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      samp_nxt  = samples;
      carry_nxt = '0;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (clear) begin
      sum_nxt = '0;
    end
  end

  // Sums are block state and start from zero; the shift data needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      sum_r  <= sum_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r  <= samp_nxt;
    carry_r <= carry_nxt;
  end

  assign sums = sum_r;
  assign done = done_r;

endmodule

// ===== rtl/gtc_div.sv =====
// Restoring divider, one quotient bit per cycle, three axis lanes under one control.
module gtc_div
  import gtc_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [NUM_AXES-1:0][SUM_W-1:0]     dividend,
  input  logic [COUNT_W-1:0]                 divisor,
  output logic [NUM_AXES-1:0][ADC_BITS-1:0]  quotient,
  output logic                               done
);

  localparam int CNT_W = $clog2(SUM_W);
  localparam int REM_W = COUNT_W;
  localparam logic [SUM_W-1:0] ADC_MAX_Q = SUM_W'((1 << ADC_BITS) - 1);

  logic [NUM_AXES-1:0][SUM_W-1:0] quo_r, quo_nxt;
  logic [NUM_AXES-1:0][REM_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0]             div_r, div_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [NUM_AXES-1:0][REM_W:0]   trial;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      trial[a] = {rem_r[a], quo_r[a][SUM_W-1]};
    end
    if (busy_r) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (trial[a] >= {1'b0, div_r}) begin
          rem_nxt[a] = REM_W'(trial[a] - {1'b0, div_r});
          quo_nxt[a] = {quo_r[a][SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt[a] = trial[a][REM_W-1:0];
          quo_nxt[a] = {quo_r[a][SUM_W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  // An average above full scale can only follow a shortened window; it saturates.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      quotient[a] = (quo_r[a] > ADC_MAX_Q) ? ADC_MAX_Q[ADC_BITS-1:0]
                                           : quo_r[a][ADC_BITS-1:0];
    end
  end

  assign done = done_r;

endmodule

// ===== rtl/gtc_match.sv =====
// Template matcher: one gesture per cycle, with the run counters and move decisions.
module gtc_match
  import gtc_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [NUM_AXES-1:0][ADC_BITS-1:0]  avg,
  input  gtc_match_cfg_t                     cfg,
  input  logic                               limit_clear,
  output gtc_match_res_t                     res,
  output logic                               done
);

  localparam int CMP_W = (ADC_BITS > FIELD_W) ? ADC_BITS : FIELD_W;

  logic [NUM_GEST-1:0][REPEAT_W-1:0] run_cnt_r, run_cnt_nxt;
  logic [1:0]                        gest_r, gest_nxt;
  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [MASK_W-1:0]                 match_r, match_nxt;
  logic [MASK_W-1:0]                 move_r, move_nxt;
  logic                              blocked_r, blocked_nxt;
  logic [TMPL_W-1:0]                 tmpl;
  logic [NUM_AXES-1:0][CMP_W-1:0]    t_field;
  logic [NUM_AXES-1:0][CMP_W-1:0]    a_field;
  logic [NUM_AXES-1:0][CMP_W-1:0]    diff;
  logic [NUM_AXES-1:0]               in_tol;
  logic                              hit;
  logic [REPEAT_W-1:0]               cnt_inc;

  // Distance of each axis from the template under test.
  always_comb begin
    tmpl = cfg.templates[gest_r];
    for (int a = 0; a < NUM_AXES; a++) begin
      t_field[a] = CMP_W'(tmpl[a*FIELD_W +: FIELD_W]);
      a_field[a] = CMP_W'(avg[a]);
      diff[a]    = (a_field[a] > t_field[a]) ? (a_field[a] - t_field[a])
                                             : (t_field[a] - a_field[a]);
      in_tol[a]  = diff[a] < CMP_W'(cfg.tolerance);
    end
    hit     = &in_tol;
    cnt_inc = run_cnt_r[gest_r] + 1'b1;
  end

  // Gestures go in order, so a later match in the same window sees the earlier one's effect.
  always_comb begin
    run_cnt_nxt = run_cnt_r;
    gest_nxt    = gest_r;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    match_nxt   = match_r;
    move_nxt    = move_r;
    blocked_nxt = blocked_r;
    if (busy_r) begin
      if (hit) begin
        match_nxt[gest_r] = 1'b1;
        run_cnt_nxt       = '0;
        if (cnt_inc >= cfg.repeat_count) begin
          if (gest_r == GEST_DOWN && !limit_clear) begin
            blocked_nxt = 1'b1;
          end else begin
            move_nxt[gest_r] = 1'b1;
          end
        end else begin
          run_cnt_nxt[gest_r] = cnt_inc;
        end
      end
      gest_nxt = gest_r + 1'b1;
      if (gest_r == GEST_REV) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      gest_nxt    = GEST_UP;
      busy_nxt    = 1'b1;
      match_nxt   = '0;
      move_nxt    = '0;
      blocked_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
      gest_r    <= GEST_UP;
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      run_cnt_r <= run_cnt_nxt;
      gest_r    <= gest_nxt;
      busy_r    <= busy_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_r   <= match_nxt;
    move_r    <= move_nxt;
    blocked_r <= blocked_nxt;
  end

  always_comb begin
    res.match_mask   = match_r;
    res.move_mask    = move_r;
    res.down_blocked = blocked_r;
  end

  assign done = done_r;

endmodule

// ===== rtl/gesture_template_classifier_top.sv =====
// Top level of the gesture template classifier: registers, window control and result stage.
//
// Each accepted sample is added into three 18-bit axis sums by a bit-serial adder, in 18
// serial add steps, and the input stalls until they are done. The sample that closes a
// window also runs an 18-step bit-serial restoring divide of the sums by the window length
// and a four-step pass over the gesture templates; the input stalls until its result has
// been handed to the output register. Results wait in that output register, so the next
// sample is taken while a result is still waiting; a new window end holds off only when
// that register is still full. The configuration port accepts a write in every cycle.
module gesture_template_classifier_top
  import gtc_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  gtc_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output gtc_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CMP_W = (ADC_BITS > FIELD_W) ? ADC_BITS : FIELD_W;
  localparam logic [CMP_W-1:0] ADC_MASK = CMP_W'((1 << ADC_BITS) - 1);

  // Control states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ACC   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MATCH = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [SCOUNT_W-1:0]           sample_count_r;
  logic [TOL_W-1:0]              tol_r;
  logic [REPEAT_W-1:0]           repeat_r;
  logic [NUM_GEST-1:0][TMPL_W-1:0] tmpl_r;
  logic [SCOUNT_W-1:0]           win_pos_r, win_pos_nxt;
  logic [COUNT_W-1:0]            count_r, count_nxt;
  logic                          win_end_r, win_end_nxt;
  logic                          limit_r, limit_nxt;
  logic                          out_valid_r, out_valid_nxt;
  gtc_out_t                      out_data_r, out_data_nxt;

  logic                          in_xfer;
  logic                          cfg_xfer;
  logic [COUNT_W-1:0]            win_len;
  logic [COUNT_W-1:0]            taken;
  logic [NUM_AXES-1:0][SUM_W-1:0] samples;
  logic [NUM_AXES-1:0][SUM_W-1:0] sums;
  logic [NUM_AXES-1:0][ADC_BITS-1:0] avg;
  logic [NUM_AXES-1:0][CMP_W-1:0] avg_ext;
  logic                          acc_start, acc_clear, acc_done;
  logic                          div_start, div_done;
  logic                          match_start, match_done;
  logic                          out_free;
  gtc_match_cfg_t                match_cfg;
  gtc_match_res_t                match_res;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;

  // Window length; a zero count means 256 samples.
  assign win_len = (sample_count_r == '0) ? COUNT_W'(1 << SCOUNT_W)
                                          : {1'b0, sample_count_r};
  assign taken   = {1'b0, win_pos_r} + 1'b1;

  // Sample bits above the converter resolution are dropped.
  assign samples[0] = SUM_W'(CMP_W'(in_data.accel_x) & ADC_MASK);
  assign samples[1] = SUM_W'(CMP_W'(in_data.accel_y) & ADC_MASK);
  assign samples[2] = SUM_W'(CMP_W'(in_data.accel_z) & ADC_MASK);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= SAMPLE_COUNT_RST;
      tol_r          <= MATCH_TOLERANCE_RST;
      repeat_r       <= REPEAT_COUNT_RST;
      tmpl_r[0]      <= TEMPLATE_UP_RST;
      tmpl_r[1]      <= TEMPLATE_DOWN_RST;
      tmpl_r[2]      <= TEMPLATE_THIRD_RST;
      tmpl_r[3]      <= TEMPLATE_FOURTH_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT:    sample_count_r <= cfg_data[SCOUNT_W-1:0];
        CFG_MATCH_TOLERANCE: tol_r          <= cfg_data[TOL_W-1:0];
        CFG_REPEAT_COUNT:    repeat_r       <= cfg_data[REPEAT_W-1:0];
        CFG_TEMPLATE_UP:     tmpl_r[0]      <= cfg_data[TMPL_W-1:0];
        CFG_TEMPLATE_DOWN:   tmpl_r[1]      <= cfg_data[TMPL_W-1:0];
        CFG_TEMPLATE_THIRD:  tmpl_r[2]      <= cfg_data[TMPL_W-1:0];
        CFG_TEMPLATE_FOURTH: tmpl_r[3]      <= cfg_data[TMPL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    match_cfg.tolerance    = tol_r;
    match_cfg.repeat_count = repeat_r;
    match_cfg.templates    = tmpl_r;
  end

  // Sequencing of add, divide, template pass and result hand-over.
  always_comb begin
    state_nxt     = state_r;
    win_pos_nxt   = win_pos_r;
    count_nxt     = count_r;
    win_end_nxt   = win_end_r;
    limit_nxt     = limit_r;
    acc_start     = 1'b0;
    acc_clear     = 1'b0;
    div_start     = 1'b0;
    match_start   = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          acc_start = 1'b1;
          limit_nxt = in_data.limit_clear;
          count_nxt = win_len;
          if (taken >= win_len) begin
            win_end_nxt = 1'b1;
            win_pos_nxt = '0;
          end else begin
            win_end_nxt = 1'b0;
            win_pos_nxt = taken[SCOUNT_W-1:0];
          end
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (acc_done) begin
          if (win_end_r) begin
            div_start = 1'b1;
            acc_clear = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          match_start = 1'b1;
          state_nxt   = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (match_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.avg_x        = avg_ext[0][FIELD_W-1:0];
          out_data_nxt.avg_y        = avg_ext[1][FIELD_W-1:0];
          out_data_nxt.avg_z        = avg_ext[2][FIELD_W-1:0];
          out_data_nxt.match_mask   = match_res.match_mask;
          out_data_nxt.move_mask    = match_res.move_mask;
          out_data_nxt.down_blocked = match_res.down_blocked;
          state_nxt                 = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      avg_ext[a] = CMP_W'(avg[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_pos_r   <= '0;
      win_end_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_pos_r   <= win_pos_nxt;
      win_end_r   <= win_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r    <= count_nxt;
    limit_r    <= limit_nxt;
    out_data_r <= out_data_nxt;
  end

  gtc_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (acc_start),
    .clear   (acc_clear),
    .samples (samples),
    .sums    (sums),
    .done    (acc_done)
  );

  gtc_div #(
    .ADC_BITS (ADC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sums),
    .divisor  (count_r),
    .quotient (avg),
    .done     (div_done)
  );

  gtc_match #(
    .ADC_BITS (ADC_BITS)
  ) u_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (match_start),
    .avg         (avg),
    .cfg         (match_cfg),
    .limit_clear (limit_r),
    .res         (match_res),
    .done        (match_done)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
